// ----- hw/rtl/sstq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstq_pkg
// Shared types, sizes and request codes for the sorted timer queue.
// ----------------------------------------------------------------------------
package sstq_pkg;

    // Number of timer slots and the widths that follow from it.
    localparam int NUM_TIMERS = 16;
    localparam int SLOT_W     = (NUM_TIMERS > 2) ? $clog2(NUM_TIMERS) : 1;
    localparam int LINK_W     = $clog2(NUM_TIMERS + 1);
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_TIMERS);

    // Fixed field widths of one item.
    localparam int REQ_W   = 2;
    localparam int FSLOT_W = 4;
    localparam int TIME_W  = 32;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_INIT  = 2'd1,
        REQ_START = 2'd2,
        REQ_SET   = 2'd3
    } req_t;

    // A link points at a slot when it is below the slot count.
    function automatic logic link_ok(input logic [LINK_W-1:0] link);
        return link < NIL_LINK;
    endfunction

    // Slot index carried by a link.
    function automatic logic [SLOT_W-1:0] link_idx(input logic [LINK_W-1:0] link);
        return SLOT_W'(link);
    endfunction

endpackage

// ----- hw/rtl/sorted_software_timer_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_software_timer_queue_top
// Timer slots kept in a linked list sorted by deadline, held in RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one request item: s_tuser carries the request
//   kind (tick, init, start, set-time) and s_tdata the slot, interval and
//   periodic flag. The master channel returns exactly one result item per
//   request: fired flag, fired slot and status.
//   Requests are handled one at a time. A start or a periodic firing walks
//   the sorted list, reading the deadline and link RAMs for each visited
//   slot, then relinks the slot before the result is handed off. The result
//   sits in an output register; a new request is taken while it waits. If
//   the receiver stalls and a second result is ready, the block holds it and
//   accepts nothing until the register frees.
//   Reset clears the tick count, the list head and all active and periodic
//   flags. Deadline, reload and link RAMs are not cleared: a slot's entries
//   must be written before the list ever reads them; the block does not enforce it.
// ----------------------------------------------------------------------------
module sorted_software_timer_queue_top
    import sstq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // slot[3:0], interval[35:4], periodic[36], zero pad
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // fired[0], fired_slot[4:1], status[5], zero pad
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_U_RD  = 11'b00000000010,
        ST_U_WR  = 11'b00000000100,
        ST_T_RD  = 11'b00000001000,
        ST_T_CMP = 11'b00000010000,
        ST_D_RD  = 11'b00000100000,
        ST_D_KEY = 11'b00001000000,
        ST_W_RD  = 11'b00010000000,
        ST_W_CMP = 11'b00100000000,
        ST_L_1   = 11'b01000000000,
        ST_L_2   = 11'b10000000000
    } state_t;

    // ST_DONE is folded in: a finished item waits in IDLE-bound hold below.
    state_t                  state_reg, state_next;
    logic                    hold_reg, hold_next;
    logic [TIME_W-1:0]       tick_reg, tick_next;
    logic [LINK_W-1:0]       head_reg, head_next;
    logic [NUM_TIMERS-1:0]   active_reg, active_next;
    logic [NUM_TIMERS-1:0]   periodic_reg, periodic_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [TIME_W-1:0]       key_reg, key_next;
    logic [LINK_W-1:0]       cur_reg, cur_next;
    logic [LINK_W-1:0]       before_reg, before_next;
    logic                    fired_reg, fired_next;
    logic                    status_reg, status_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [7:0]              m_tdata_reg, m_tdata_next;

    // Input fields.
    logic [FSLOT_W-1:0] in_slot;
    logic [TIME_W-1:0]  in_interval;
    logic               in_periodic;
    req_t               in_req;
    logic [SLOT_W-1:0]  in_idx;
    logic               in_slot_ok;
    logic               accept;

    // RAM ports.
    logic                    dl_we, rl_we, nx_we, pv_we;
    logic [SLOT_W-1:0]       dl_waddr, nx_waddr, pv_waddr;
    logic [SLOT_W-1:0]       dl_raddr, rl_raddr, nx_raddr, pv_raddr;
    logic [TIME_W-1:0]       dl_wdata, dl_rdata, rl_rdata;
    logic [LINK_W-1:0]       nx_wdata, pv_wdata, nx_rdata, pv_rdata;

    assign in_slot     = s_tdata[3:0];
    assign in_interval = s_tdata[35:4];
    assign in_periodic = s_tdata[36];
    assign in_req      = req_t'(s_tuser);
    assign in_idx      = SLOT_W'(in_slot);
    assign in_slot_ok  = 32'(in_slot) < NUM_TIMERS;

    assign s_tready = (state_reg == ST_IDLE) && !hold_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Slot RAMs: deadline, reload, next link and previous link.
    sstq_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TIMERS)) u_deadline_ram (
        .aclk(aclk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
        .raddr(dl_raddr), .rdata(dl_rdata)
    );
    sstq_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TIMERS)) u_reload_ram (
        .aclk(aclk), .we(rl_we), .waddr(in_idx), .wdata(in_interval),
        .raddr(rl_raddr), .rdata(rl_rdata)
    );
    sstq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_TIMERS)) u_next_ram (
        .aclk(aclk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(nx_raddr), .rdata(nx_rdata)
    );
    sstq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_TIMERS)) u_prev_ram (
        .aclk(aclk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(pv_raddr), .rdata(pv_rdata)
    );

    // Request sequencer: accept, unlink, tick check, sorted walk, relink.
    always_comb begin
        state_next    = state_reg;
        hold_next     = hold_reg;
        tick_next     = tick_reg;
        head_next     = head_reg;
        active_next   = active_reg;
        periodic_next = periodic_reg;
        slot_next     = slot_reg;
        key_next      = key_reg;
        cur_next      = cur_reg;
        before_next   = before_reg;
        fired_next    = fired_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        dl_we    = 1'b0;
        dl_waddr = in_idx;
        dl_wdata = in_interval + tick_reg;
        dl_raddr = slot_reg;
        rl_we    = 1'b0;
        rl_raddr = link_idx(head_reg);
        nx_we    = 1'b0;
        nx_waddr = slot_reg;
        nx_wdata = NIL_LINK;
        nx_raddr = slot_reg;
        pv_we    = 1'b0;
        pv_waddr = slot_reg;
        pv_wdata = NIL_LINK;
        pv_raddr = slot_reg;

        // The output register drains independently of the sequencer.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    slot_next   = in_idx;
                    fired_next  = 1'b0;
                    status_next = 1'b0;
                    hold_next   = 1'b1;
                    if (in_req == REQ_TICK) begin
                        tick_next = tick_reg + 1'b1;
                        if (link_ok(head_reg)) begin
                            hold_next  = 1'b0;
                            state_next = ST_T_RD;
                        end
                    end else if (!in_slot_ok) begin
                        status_next = 1'b1;
                    end else if (in_req == REQ_START) begin
                        if (active_reg[in_idx]) begin
                            status_next = 1'b1;
                        end else begin
                            active_next[in_idx] = 1'b1;
                            hold_next           = 1'b0;
                            state_next          = ST_D_RD;
                        end
                    end else begin
                        // Init and set-time write the new deadline at once.
                        dl_we = 1'b1;
                        if (in_req == REQ_INIT) begin
                            rl_we                 = 1'b1;
                            periodic_next[in_idx] = in_periodic;
                        end
                        if (active_reg[in_idx]) begin
                            active_next[in_idx] = 1'b0;
                            hold_next           = 1'b0;
                            state_next          = ST_U_RD;
                        end
                    end
                end
            end
            ST_U_RD: begin
                hold_next  = 1'b1;
                state_next = ST_U_WR;
            end
            ST_U_WR: begin
                // Bridge the neighbors of the removed slot.
                if (link_ok(pv_rdata)) begin
                    nx_we    = 1'b1;
                    nx_waddr = link_idx(pv_rdata);
                    nx_wdata = nx_rdata;
                end else begin
                    head_next = nx_rdata;
                end
                if (link_ok(nx_rdata)) begin
                    pv_we    = 1'b1;
                    pv_waddr = link_idx(nx_rdata);
                    pv_wdata = pv_rdata;
                end
                state_next = ST_IDLE;
            end
            ST_T_RD: begin
                dl_raddr   = link_idx(head_reg);
                nx_raddr   = link_idx(head_reg);
                state_next = ST_T_CMP;
            end
            ST_T_CMP: begin
                hold_next  = 1'b1;
                state_next = ST_IDLE;
                if (dl_rdata <= tick_reg) begin
                    // The head expires: pop it off the list.
                    fired_next = 1'b1;
                    slot_next  = link_idx(head_reg);
                    head_next  = nx_rdata;
                    if (link_ok(nx_rdata)) begin
                        pv_we    = 1'b1;
                        pv_waddr = link_idx(nx_rdata);
                        pv_wdata = NIL_LINK;
                    end
                    if (periodic_reg[link_idx(head_reg)]) begin
                        key_next    = rl_rdata + tick_reg;
                        dl_we       = 1'b1;
                        dl_waddr    = link_idx(head_reg);
                        dl_wdata    = rl_rdata + tick_reg;
                        cur_next    = nx_rdata;
                        before_next = NIL_LINK;
                        hold_next   = 1'b0;
                        state_next  = ST_W_RD;
                    end else begin
                        active_next[link_idx(head_reg)] = 1'b0;
                    end
                end
            end
            ST_D_RD: begin
                state_next = ST_D_KEY;
            end
            ST_D_KEY: begin
                key_next    = dl_rdata;
                cur_next    = head_reg;
                before_next = NIL_LINK;
                state_next  = ST_W_RD;
            end
            ST_W_RD: begin
                dl_raddr = link_idx(cur_reg);
                nx_raddr = link_idx(cur_reg);
                if (link_ok(cur_reg)) begin
                    state_next = ST_W_CMP;
                end else begin
                    state_next = ST_L_1;
                end
            end
            ST_W_CMP: begin
                // Stop before the first slot with a later deadline.
                if (dl_rdata > key_reg) begin
                    state_next = ST_L_1;
                end else begin
                    before_next = cur_reg;
                    cur_next    = nx_rdata;
                    state_next  = ST_W_RD;
                end
            end
            ST_L_1: begin
                nx_we      = 1'b1;
                nx_wdata   = cur_reg;
                pv_we      = 1'b1;
                pv_wdata   = before_reg;
                state_next = ST_L_2;
            end
            ST_L_2: begin
                if (link_ok(before_reg)) begin
                    nx_we    = 1'b1;
                    nx_waddr = link_idx(before_reg);
                    nx_wdata = LINK_W'(slot_reg);
                end else begin
                    head_next = LINK_W'(slot_reg);
                end
                if (link_ok(cur_reg)) begin
                    pv_we    = 1'b1;
                    pv_waddr = link_idx(cur_reg);
                    pv_wdata = LINK_W'(slot_reg);
                end
                hold_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A finished item moves to the output register once it is free.
        if (hold_reg && (!m_tvalid_reg || m_tready)) begin
            hold_next     = 1'b0;
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, status_reg,
                             fired_reg ? FSLOT_W'(slot_reg) : {FSLOT_W{1'b0}},
                             fired_reg};
        end
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            hold_reg     <= 1'b0;
            tick_reg     <= '0;
            head_reg     <= NIL_LINK;
            active_reg   <= '0;
            periodic_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hold_reg     <= hold_next;
            tick_reg     <= tick_next;
            head_reg     <= head_next;
            active_reg   <= active_next;
            periodic_reg <= periodic_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        slot_reg    <= slot_next;
        key_reg     <= key_next;
        cur_reg     <= cur_next;
        before_reg  <= before_next;
        fired_reg   <= fired_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef ASSERT_OFF
    // One item at a time: no accept directly after an accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while the previous one is in work");

    // A firing result never reports an ignored request.
    a_fired_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> !m_tdata[5])
        else $error("fired result carries ignored status");

    // Between requests the list head is empty or an active slot.
    a_head_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && link_ok(head_reg)) |-> active_reg[link_idx(head_reg)])
        else $error("list head is not an active slot");
`endif

endmodule

// ----- hw/rtl/sstq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sstq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- test/sorted_software_timer_queue_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_software_timer_queue_top_tb
// Self-checking bench for the sorted timer queue.
// ----------------------------------------------------------------------------
// Requests of all kinds are streamed in with random gaps. A behavioral copy
// of the sorted list predicts each result item, and the monitor compares the
// items that come out with those predictions, oldest first. The receiver
// stalls at random and once holds off for a long stretch to fill the block.
// ----------------------------------------------------------------------------
module sorted_software_timer_queue_top_tb;
    import sstq_pkg::*;

    localparam int NIL = NUM_TIMERS;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [31:0] interval;
        logic        periodic;
    } request_t;

    // Laid out as on m_tdata[5:0]: fired in the lowest bit.
    typedef struct packed {
        logic       status;
        logic [3:0] fired_slot;
        logic       fired;
    } outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    sorted_software_timer_queue_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Predicted timer state.
    logic [31:0] ticks;
    logic [31:0] due [NUM_TIMERS];
    logic [31:0] period [NUM_TIMERS];
    logic        repeating [NUM_TIMERS];
    logic        armed [NUM_TIMERS];
    logic        written [NUM_TIMERS];
    int          succ [NUM_TIMERS];
    int          pred [NUM_TIMERS];
    int          first;

    request_t pending_requests [$];
    outcome_t expected_outcomes [$];
    int       errors = 0;
    bit       quiet_phase = 1'b0;
    bit       stimulus_done = 1'b0;
    bit       hold_go = 1'b0;
    bit       hold_taken = 1'b0;
    int       hold_cycles = 0;
    logic     s_tready_seen = 1'b0;

    // Take a slot out of the list.
    function automatic void detach(input int s);
        if (pred[s] != NIL) succ[pred[s]] = succ[s];
        else first = succ[s];
        if (succ[s] != NIL) pred[succ[s]] = pred[s];
        succ[s] = NIL;
        pred[s] = NIL;
    endfunction

    // Link a slot after every slot due at or before it.
    function automatic void attach_sorted(input int s);
        int after_slot;
        int cur;
        after_slot = NIL;
        cur = first;
        while (cur != NIL && due[cur] <= due[s]) begin
            after_slot = cur;
            cur = succ[cur];
        end
        pred[s] = after_slot;
        succ[s] = cur;
        if (after_slot != NIL) succ[after_slot] = s;
        else first = s;
        if (cur != NIL) pred[cur] = s;
    endfunction

    // Apply one request to the predicted state and return its result item.
    function automatic outcome_t apply_request(input request_t r);
        outcome_t o;
        int h;
        o = '0;
        case (req_t'(r.kind))
            REQ_TICK: begin
                ticks = ticks + 32'd1;
                if (first != NIL && due[first] <= ticks) begin
                    h = first;
                    detach(h);
                    o.fired = 1'b1;
                    o.fired_slot = h[3:0];
                    if (repeating[h]) begin
                        due[h] = period[h] + ticks;
                        attach_sorted(h);
                    end else begin
                        armed[h] = 1'b0;
                    end
                end
            end
            REQ_INIT: begin
                if (armed[r.slot]) begin
                    detach(r.slot);
                    armed[r.slot] = 1'b0;
                end
                period[r.slot] = r.interval;
                repeating[r.slot] = r.periodic;
                due[r.slot] = r.interval + ticks;
                written[r.slot] = 1'b1;
            end
            REQ_START: begin
                if (armed[r.slot]) begin
                    o.status = 1'b1;
                end else begin
                    attach_sorted(r.slot);
                    armed[r.slot] = 1'b1;
                end
            end
            default: begin
                if (armed[r.slot]) begin
                    detach(r.slot);
                    armed[r.slot] = 1'b0;
                end
                due[r.slot] = r.interval + ticks;
                written[r.slot] = 1'b1;
            end
        endcase
        return o;
    endfunction

    // Queue a request; a start of a slot never given a deadline is swapped
    // for an init so that no unwritten entry is ever read.
    task automatic queue_request(input req_t kind, input int s, input logic [31:0] iv,
                                 input logic per);
        request_t r;
        r.kind = kind;
        r.slot = s[3:0];
        r.interval = iv;
        r.periodic = per;
        if (kind == REQ_START && !written[s]) r.kind = REQ_INIT;
        if (r.kind == REQ_INIT || r.kind == REQ_SET) written[s] = 1'b1;
        pending_requests.push_back(r);
    endtask

    // Short intervals so that timers actually expire within the run.
    function automatic logic [31:0] short_interval();
        return $urandom_range(7) == 0 ? $urandom() : 32'($urandom_range(0, 40));
    endfunction

    // Driver: offers queued items at the falling edge with random gaps.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_seen) begin
                if (pending_requests.size() > 0 &&
                    (quiet_phase || $urandom_range(99) >= 18)) begin
                    request_t r;
                    r = pending_requests.pop_front();
                    expected_outcomes.push_back(apply_request(r));
                    s_tuser <= r.kind;
                    s_tdata <= {3'b0, r.periodic, r.interval, r.slot};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Handshake flag captured at the rising edge for the driver.
    always @(posedge aclk) s_tready_seen <= s_tvalid && s_tready;

    // Receiver readiness, with one long hold-off while input keeps coming.
    always @(negedge aclk) begin
        if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cycles <= 399;
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet_phase || $urandom_range(99) >= 18;
        end
    end

    // Monitor: compares each result item with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            outcome_t got;
            outcome_t want;
            got = outcome_t'(m_tdata[5:0]);
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual %h", $time,
                         m_tdata);
                errors = errors + 1;
            end else begin
                want = expected_outcomes.pop_front();
                if (got.fired !== want.fired) begin
                    $display("%0t: fired mismatch, expected %0d, actual %0d", $time,
                             want.fired, got.fired);
                    errors = errors + 1;
                end
                if (got.fired_slot !== want.fired_slot) begin
                    $display("%0t: fired_slot mismatch, expected %0d, actual %0d", $time,
                             want.fired_slot, got.fired_slot);
                    errors = errors + 1;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                             want.status, got.status);
                    errors = errors + 1;
                end
                if (m_tdata[7:6] !== 2'b0) begin
                    $display("%0t: pad bits, expected 0, actual %b", $time, m_tdata[7:6]);
                    errors = errors + 1;
                end
            end
        end
    end

    // Stimulus.
    initial begin
        int k;
        int s;
        ticks = '0;
        first = NIL;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            due[i] = '0;
            period[i] = '0;
            repeating[i] = 1'b0;
            armed[i] = 1'b0;
            written[i] = 1'b0;
            succ[i] = NIL;
            pred[i] = NIL;
        end

        // Directed: extremes, equal deadlines, restart, overflow, one-shot.
        queue_request(REQ_TICK, 0, 32'h0, 1'b0);
        queue_request(REQ_INIT, 0, 32'd2, 1'b1);
        queue_request(REQ_INIT, 15, 32'd2, 1'b0);
        queue_request(REQ_INIT, 5, 32'hFFFF_FFFF, 1'b1);
        queue_request(REQ_START, 0, 32'h0, 1'b0);
        queue_request(REQ_START, 15, 32'h0, 1'b0);
        queue_request(REQ_START, 5, 32'h0, 1'b0);
        queue_request(REQ_START, 0, 32'hFFFF_FFFF, 1'b1);
        queue_request(REQ_TICK, 15, 32'hFFFF_FFFF, 1'b1);
        queue_request(REQ_TICK, 0, 32'h0, 1'b0);
        queue_request(REQ_TICK, 0, 32'h0, 1'b0);
        queue_request(REQ_INIT, 0, 32'd0, 1'b0);
        queue_request(REQ_SET, 15, 32'd1, 1'b0);
        queue_request(REQ_START, 15, 32'h0, 1'b0);
        queue_request(REQ_SET, 5, 32'hAAAA_5555, 1'b1);
        queue_request(REQ_START, 0, 32'h0, 1'b0);
        queue_request(REQ_TICK, 0, 32'h0, 1'b0);
        queue_request(REQ_TICK, 0, 32'h0, 1'b0);
        queue_request(REQ_TICK, 0, 32'h0, 1'b0);
        queue_request(REQ_SET, 7, 32'h5555_AAAA, 1'b0);

        // Random: mostly init/start pairs and ticks, some noise.
        for (k = 0; k < 830; k++) begin
            s = $urandom_range(NUM_TIMERS - 1);
            case ($urandom_range(9))
                0, 1, 2, 3: queue_request(REQ_TICK, $urandom_range(15), $urandom(),
                                          1'($urandom()));
                4, 5: begin
                    queue_request(REQ_INIT, s, short_interval(), 1'($urandom()));
                    queue_request(REQ_START, s, $urandom(), 1'($urandom()));
                    k++;
                end
                6: queue_request(REQ_START, s, $urandom(), 1'($urandom()));
                7: queue_request(REQ_SET, s, short_interval(), 1'($urandom()));
                8: queue_request(REQ_INIT, s, short_interval(), 1'($urandom()));
                default: begin
                    queue_request(REQ_SET, s, short_interval(), 1'($urandom()));
                    queue_request(REQ_START, s, $urandom(), 1'($urandom()));
                    k++;
                end
            endcase
        end
        // The driver predicts as it sends, so reset the model to start state.
        ticks = '0;
        first = NIL;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            armed[i] = 1'b0;
            repeating[i] = 1'b0;
            succ[i] = NIL;
            pred[i] = NIL;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Long hold-off on the receiver early in the run.
        repeat (30) @(posedge aclk);
        hold_go = 1'b1;
        repeat (2000) @(posedge aclk);
        quiet_phase = 1'b1;
        repeat (1500) @(posedge aclk);
        quiet_phase = 1'b0;

        wait (pending_requests.size() == 0);
        @(posedge aclk);
        while (s_tvalid) @(posedge aclk);
        wait (expected_outcomes.size() == 0);
        repeat (2 * NUM_TIMERS + 20) @(posedge aclk);
        if (errors == 0 && expected_outcomes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Timeout.
    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
